// File: rtl/core/oteps_pkg.sv
package oteps_pkg;

  localparam int unsigned MAX_CHARS     = 65536;
  localparam int unsigned DEFAULT_LIMIT = 1000;
  localparam int unsigned HISTORY_DEPTH = 1024;

  localparam int unsigned VER_W      = 32;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned LIMIT_W    = 11;
  localparam int unsigned ENTRY_W    = KIND_W + POS_W;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LENGTH = 1'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_NOOP = 2'd0,
    KIND_INS  = 2'd1,
    KIND_DEL  = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_INVALID      = 3'd1,
    ST_NOT_ONE_CHAR = 3'd2,
    ST_EXPIRED      = 3'd3,
    ST_AHEAD        = 3'd4
  } status_e;

  // request from the sequencer to the history walker
  typedef struct packed {
    logic             start;
    logic [VER_W-1:0] base;
    logic [VER_W-1:0] ver_first;
    kind_e            kind;
    logic [POS_W-1:0] pos;
  } walk_req_t;

  // walker status back to the sequencer
  typedef struct packed {
    logic  done;
    kind_e kind;
  } walk_rsp_t;

endpackage

// File: rtl/core/oteps_hist_mem.sv
module oteps_hist_mem #(
  parameter int unsigned DEPTH = oteps_pkg::HISTORY_DEPTH,
  parameter int unsigned WIDTH = oteps_pkg::ENTRY_W
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/oteps_walker.sv
module oteps_walker #(
  parameter int unsigned DEPTH = oteps_pkg::HISTORY_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  oteps_pkg::walk_req_t      req_i,
  input  logic [$clog2(DEPTH)-1:0]  head_i,
  input  logic [$clog2(DEPTH+1)-1:0] fill_i,
  output logic                      rd_en_o,
  output logic [$clog2(DEPTH)-1:0]  rd_addr_o,
  input  logic [oteps_pkg::ENTRY_W-1:0] rd_data_i,
  output oteps_pkg::walk_rsp_t      rsp_o,
  output logic [$clog2(oteps_pkg::MAX_CHARS+DEPTH)-1:0] e_pos_o
);

  localparam int unsigned HW     = $clog2(DEPTH);
  localparam int unsigned FW     = $clog2(DEPTH + 1);
  localparam int unsigned EPOS_W = $clog2(oteps_pkg::MAX_CHARS + DEPTH);
  localparam int unsigned VW     = oteps_pkg::VER_W;
  localparam int unsigned PW     = oteps_pkg::POS_W;
  localparam int unsigned KW     = oteps_pkg::KIND_W;

  logic [FW-1:0]     cnt_q, cnt_d;
  logic [HW-1:0]     addr_q, addr_d;
  logic [VW-1:0]     ver_q, ver_d;
  logic [VW-1:0]     base_q, base_d;
  logic              pend_q, pend_d;
  logic              newer_q, newer_d;
  logic              last_q, last_d;
  logic              done_q, done_d;
  oteps_pkg::kind_e  e_kind_q, e_kind_d;
  logic [EPOS_W-1:0] e_pos_q, e_pos_d;

  oteps_pkg::kind_e  p_kind;
  logic [EPOS_W-1:0] p_pos;

  // read issue: one entry per cycle, oldest first
  always_comb begin
    cnt_d   = cnt_q;
    addr_d  = addr_q;
    ver_d   = ver_q;
    base_d  = base_q;
    pend_d  = 1'b0;
    newer_d = newer_q;
    last_d  = last_q;
    if (req_i.start) begin
      cnt_d  = fill_i;
      addr_d = head_i;
      ver_d  = req_i.ver_first;
      base_d = req_i.base;
    end else if (cnt_q != '0) begin
      pend_d  = 1'b1;
      newer_d = (ver_q > base_q);
      last_d  = (cnt_q == FW'(1));
      cnt_d   = cnt_q - FW'(1);
      ver_d   = ver_q + VW'(1);
      addr_d  = (addr_q == HW'(DEPTH - 1)) ? '0 : addr_q + HW'(1);
    end
  end

  assign rd_en_o   = !req_i.start && (cnt_q != '0);
  assign rd_addr_o = addr_q;

  assign p_kind = oteps_pkg::kind_e'(rd_data_i[oteps_pkg::ENTRY_W-1 -: KW]);
  assign p_pos  = EPOS_W'(rd_data_i[PW-1:0]);

  // transform the edit past one stored entry
  always_comb begin
    e_kind_d = e_kind_q;
    e_pos_d  = e_pos_q;
    if (req_i.start) begin
      e_kind_d = req_i.kind;
      e_pos_d  = (req_i.kind == oteps_pkg::KIND_NOOP) ? '0 : EPOS_W'(req_i.pos);
    end else if (pend_q && newer_q && (e_kind_q != oteps_pkg::KIND_NOOP)) begin
      unique case (p_kind)
        oteps_pkg::KIND_INS: begin
          if (p_pos <= e_pos_q) begin
            e_pos_d = e_pos_q + EPOS_W'(1);
          end
        end
        oteps_pkg::KIND_DEL: begin
          if (p_pos < e_pos_q) begin
            e_pos_d = e_pos_q - EPOS_W'(1);
          end else if ((p_pos == e_pos_q) && (e_kind_q == oteps_pkg::KIND_DEL)) begin
            e_kind_d = oteps_pkg::KIND_NOOP;
            e_pos_d  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign done_d = (req_i.start && (fill_i == '0)) || (pend_q && last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    ver_q    <= ver_d;
    base_q   <= base_d;
    newer_q  <= newer_d;
    last_q   <= last_d;
    e_kind_q <= e_kind_d;
    e_pos_q  <= e_pos_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.kind = e_kind_q;
  assign e_pos_o    = e_pos_q;

endmodule

// File: rtl/core/ot_edit_position_sequencer.sv
// channel   | direction | transfer when            | payload
// s_axis    | in        | s_axis_tvalid & tready   | one edit: base version, kind, position
// m_axis    | out       | m_axis_tvalid & tready   | status, applied edit, version, length
// cfg       | in        | cfg_valid_i & cfg_ready_o| register index and write data
//
// an accepted edit is moved past the kept history entries (at most HISTORY_DEPTH),
// oldest first, in a walk over the history memory, one read per cycle on its single
// read port; it is then clamped to the length, appended and passed to the result step
// a rejected edit goes from idle straight to the result step, with no walk
// reset clears version, history pointers and length; the memory itself is not cleared,
// only entries written by earlier appends are ever read
// a result waits in the output register while the next edit is taken; a stalled
// m_axis only holds the sequencer at its final step
module ot_edit_position_sequencer #(
  parameter int unsigned HISTORY_DEPTH = oteps_pkg::HISTORY_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // edit input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] client_base, [47:32] op_pos, [48] insert_single_char, [55:49] zero
  input  logic [55:0]                         s_axis_tdata,
  // [1:0] op_kind
  input  logic [oteps_pkg::KIND_W-1:0]        s_axis_tuser,
  // result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] applied_pos, [47:16] cur_version, [79:48] oldest_base,
  // [96:80] doc_length, [103:97] zero
  output logic [103:0]                        m_axis_tdata,
  // [2:0] status, [4:3] applied_kind
  output logic [4:0]                          m_axis_tuser,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [oteps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [oteps_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned HW     = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW     = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned LW     = (FW > oteps_pkg::LIMIT_W) ? FW : oteps_pkg::LIMIT_W;
  localparam int unsigned EPOS_W = $clog2(oteps_pkg::MAX_CHARS + HISTORY_DEPTH);
  localparam int unsigned VW     = oteps_pkg::VER_W;
  localparam int unsigned PW     = oteps_pkg::POS_W;
  localparam int unsigned LENW   = oteps_pkg::LEN_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_NORM   = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]                   state_q, state_d;

  // document state
  logic [VW-1:0]                vc_q, vc_d;
  logic [VW-1:0]                hist_start_q, hist_start_d;
  logic [LENW-1:0]              text_len_q, text_len_d;
  logic [HW-1:0]                hist_head_q, hist_head_d;
  logic [FW-1:0]                hist_fill_q, hist_fill_d;
  logic [oteps_pkg::LIMIT_W-1:0] hist_limit_q, hist_limit_d;

  // per-edit result
  oteps_pkg::status_e           status_q, status_d;
  oteps_pkg::kind_e             res_kind_q, res_kind_d;
  logic [PW-1:0]                res_pos_q, res_pos_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  oteps_pkg::status_e           out_status_q;
  oteps_pkg::kind_e             out_kind_q;
  logic [PW-1:0]                out_pos_q;
  logic [VW-1:0]                out_ver_q;
  logic [VW-1:0]                out_start_q;
  logic [LENW-1:0]              out_len_q;
  logic                         out_load;

  // input fields
  logic [VW-1:0]                in_base;
  oteps_pkg::kind_e             in_kind;
  logic [PW-1:0]                in_pos;
  logic                         in_single;
  logic                         in_xfer;
  oteps_pkg::status_e           in_status;

  logic [FW-1:0]                eff_lim;
  logic [LW-1:0]                lim_raw;
  logic [FW-1:0]                drop;
  logic [FW:0]                  head_sum;
  logic [FW:0]                  wr_sum;
  logic [FW-1:0]                fill_inc;
  logic [EPOS_W-1:0]            len_ext;

  oteps_pkg::walk_req_t         walk_req;
  oteps_pkg::walk_rsp_t         walk_rsp;
  logic [EPOS_W-1:0]            walk_pos;

  logic                         rd_en;
  logic [HW-1:0]                rd_addr;
  logic [oteps_pkg::ENTRY_W-1:0] rd_data;
  logic                         wr_en;
  logic [HW-1:0]                wr_addr;

  assign in_base   = s_axis_tdata[31:0];
  assign in_pos    = s_axis_tdata[47:32];
  assign in_single = s_axis_tdata[48];
  assign in_kind   = oteps_pkg::kind_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // acceptance checks, in priority order
  always_comb begin
    priority if (in_kind == oteps_pkg::KIND_BAD) begin
      in_status = oteps_pkg::ST_INVALID;
    end else if ((in_kind == oteps_pkg::KIND_INS) && !in_single) begin
      in_status = oteps_pkg::ST_NOT_ONE_CHAR;
    end else if (in_base < hist_start_q) begin
      in_status = oteps_pkg::ST_EXPIRED;
    end else if (in_base > vc_q) begin
      in_status = oteps_pkg::ST_AHEAD;
    end else begin
      in_status = oteps_pkg::ST_OK;
    end
  end

  // kept-entry limit: zero selects the default, saturate to the memory depth
  always_comb begin
    lim_raw = (hist_limit_q == '0) ? LW'(oteps_pkg::DEFAULT_LIMIT) : LW'(hist_limit_q);
    eff_lim = (lim_raw > LW'(HISTORY_DEPTH)) ? FW'(HISTORY_DEPTH) : lim_raw[FW-1:0];
  end

  assign walk_req.start     = in_xfer && (in_status == oteps_pkg::ST_OK);
  assign walk_req.base      = in_base;
  assign walk_req.ver_first = vc_q - VW'(hist_fill_q) + VW'(1);
  assign walk_req.kind      = in_kind;
  assign walk_req.pos       = in_pos;

  assign drop     = hist_fill_q - eff_lim + FW'(1);
  assign head_sum = (FW+1)'(hist_head_q) + (FW+1)'(drop);
  assign wr_sum   = (FW+1)'(hist_head_q) + (FW+1)'(hist_fill_q);
  assign fill_inc = hist_fill_q + FW'(1);
  assign len_ext  = EPOS_W'(text_len_q);

  // append address wraps around the circular history
  assign wr_addr = (wr_sum >= (FW+1)'(HISTORY_DEPTH)) ?
                   HW'(wr_sum - (FW+1)'(HISTORY_DEPTH)) : HW'(wr_sum);
  assign wr_en   = (state_q == S_APPEND);

  assign out_load = (state_q == S_RESULT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    vc_d         = vc_q;
    hist_start_d = hist_start_q;
    text_len_d   = text_len_q;
    hist_head_d  = hist_head_q;
    hist_fill_d  = hist_fill_q;
    hist_limit_d = hist_limit_q;
    status_d     = status_q;
    res_kind_d   = res_kind_q;
    res_pos_d    = res_pos_q;

    // configuration writes must only come while idle; the block itself does not enforce it
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == oteps_pkg::REG_HISTORY_LIMIT) begin
        hist_limit_d = cfg_data_i[oteps_pkg::LIMIT_W-1:0];
      end else if (cfg_index_i == oteps_pkg::REG_INITIAL_LENGTH) begin
        text_len_d = (cfg_data_i > LENW'(oteps_pkg::MAX_CHARS)) ?
                     LENW'(oteps_pkg::MAX_CHARS) : LENW'(cfg_data_i);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          status_d   = in_status;
          res_kind_d = oteps_pkg::KIND_NOOP;
          res_pos_d  = '0;
          state_d    = (in_status == oteps_pkg::ST_OK) ? S_WALK : S_RESULT;
        end
      end
      S_WALK: begin
        if (walk_rsp.done) begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        // clamp against the current length, then drop entries beyond the limit
        res_kind_d = oteps_pkg::KIND_NOOP;
        res_pos_d  = '0;
        unique case (walk_rsp.kind)
          oteps_pkg::KIND_INS: begin
            if (text_len_q < LENW'(oteps_pkg::MAX_CHARS)) begin
              res_kind_d = oteps_pkg::KIND_INS;
              res_pos_d  = (walk_pos > len_ext) ? text_len_q[PW-1:0] : walk_pos[PW-1:0];
              text_len_d = text_len_q + LENW'(1);
            end
          end
          oteps_pkg::KIND_DEL: begin
            if (walk_pos < len_ext) begin
              res_kind_d = oteps_pkg::KIND_DEL;
              res_pos_d  = walk_pos[PW-1:0];
              text_len_d = text_len_q - LENW'(1);
            end
          end
          default: begin
          end
        endcase
        vc_d = vc_q + VW'(1);
        if (hist_fill_q >= eff_lim) begin
          hist_head_d = (head_sum >= (FW+1)'(HISTORY_DEPTH)) ?
                        HW'(head_sum - (FW+1)'(HISTORY_DEPTH)) : HW'(head_sum);
          hist_fill_d = hist_fill_q - drop;
        end
        state_d = S_APPEND;
      end
      S_APPEND: begin
        hist_fill_d  = fill_inc;
        hist_start_d = vc_q - VW'(fill_inc);
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      vc_q         <= '0;
      hist_start_q <= '0;
      text_len_q   <= '0;
      hist_head_q  <= '0;
      hist_fill_q  <= '0;
      hist_limit_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      vc_q         <= vc_d;
      hist_start_q <= hist_start_d;
      text_len_q   <= text_len_d;
      hist_head_q  <= hist_head_d;
      hist_fill_q  <= hist_fill_d;
      hist_limit_q <= hist_limit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    res_kind_q <= res_kind_d;
    res_pos_q  <= res_pos_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_kind_q   <= res_kind_q;
      out_pos_q    <= res_pos_q;
      out_ver_q    <= vc_q;
      out_start_q  <= hist_start_q;
      out_len_q    <= text_len_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_len_q, out_start_q, out_ver_q, out_pos_q};
  assign m_axis_tuser  = {out_kind_q, out_status_q};

  oteps_hist_mem #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (oteps_pkg::ENTRY_W)
  ) u_hist_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i ({res_kind_q, res_pos_q}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  oteps_walker #(
    .DEPTH (HISTORY_DEPTH)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (walk_req),
    .head_i    (hist_head_q),
    .fill_i    (hist_fill_q),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .rsp_o     (walk_rsp),
    .e_pos_o   (walk_pos)
  );

  // the walker only finishes while the sequencer waits for it
  a_walk_done_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_rsp.done |-> (state_q == S_WALK))
    else $error("walker done outside of walk state");

  // an append never leaves more entries than the limit allows
  a_fill_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPEND) |=> (hist_fill_q <= $past(eff_lim)))
    else $error("history fill exceeds limit after append");

  // a result appears only out of the result step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == S_RESULT))
    else $error("output valid rose outside result step");

  // rejected edits carry a noop at position zero
  a_reject_is_noop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_status_q != oteps_pkg::ST_OK)) |->
    ((out_kind_q == oteps_pkg::KIND_NOOP) && (out_pos_q == '0)))
    else $error("rejected edit reports an applied op");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_CAP       = 3_000_000;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned EDITS_PER_PHASE = 75;

  localparam int unsigned VER_W         = oteps_pkg::VER_W;
  localparam int unsigned POS_W         = oteps_pkg::POS_W;
  localparam int unsigned LEN_W         = oteps_pkg::LEN_W;
  localparam int unsigned KIND_W        = oteps_pkg::KIND_W;
  localparam int unsigned LIMIT_W       = oteps_pkg::LIMIT_W;
  localparam int unsigned CFG_IDX_W     = oteps_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W    = oteps_pkg::CFG_DATA_W;
  localparam int unsigned HISTORY_DEPTH = oteps_pkg::HISTORY_DEPTH;
  localparam int unsigned MAX_CHARS     = oteps_pkg::MAX_CHARS;
  localparam int unsigned DEFAULT_LIMIT = oteps_pkg::DEFAULT_LIMIT;

  // one edit as it crosses s_axis
  typedef struct packed {
    logic [VER_W-1:0] base;
    oteps_pkg::kind_e kind;
    logic [POS_W-1:0] pos;
    logic             single;
  } edit_req_t;

  // one applied edit as kept in the history
  typedef struct packed {
    oteps_pkg::kind_e kind;
    logic [POS_W-1:0] pos;
  } hist_entry_t;

  // one result as it crosses m_axis
  typedef struct packed {
    oteps_pkg::status_e status;
    oteps_pkg::kind_e   kind;
    logic [POS_W-1:0]   pos;
    logic [VER_W-1:0]   ver;
    logic [VER_W-1:0]   oldest;
    logic [LEN_W-1:0]   len;
  } reply_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [31:0] client_base, [47:32] op_pos, [48] insert_single_char, [55:49] zero
  logic [55:0]           s_axis_tdata  = '0;
  // [1:0] op_kind
  logic [KIND_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [15:0] applied_pos, [47:16] cur_version, [79:48] oldest_base, [96:80] doc_length
  logic [103:0]          m_axis_tdata;
  // [2:0] status, [4:3] applied_kind
  logic [4:0]            m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  ot_edit_position_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the sequencer state, advanced once per accepted edit
  logic [LIMIT_W-1:0] limit_reg = '0;
  logic [VER_W-1:0]   ver_now   = '0;
  logic [VER_W-1:0]   start_ver = '0;
  logic [LEN_W-1:0]   len_now   = '0;
  hist_entry_t        hist_mem [HISTORY_DEPTH];
  int unsigned        hist_head = 0;
  int unsigned        hist_fill = 0;

  edit_req_t   edits_waiting[$];
  reply_t      replies_due[$];
  int unsigned edits_posted = 0;
  int unsigned edits_taken  = 0;
  int unsigned replies_seen = 0;
  int unsigned failures     = 0;
  int unsigned cycles       = 0;
  int unsigned status_tally [5] = '{default: 0};
  int unsigned kind_tally   [3] = '{default: 0};
  logic        calm_tail    = 1'b0;

  // history limit and initial length for each random phase, the last one without idling
  logic [CFG_DATA_W-1:0] phase_limit  [PHASES] = '{17'd0, 17'd3, 17'd1, 17'h1FC03, 17'd2047,
                                                   17'd2};
  logic [CFG_DATA_W-1:0] phase_length [PHASES] = '{17'd40, 17'd10, 17'd0, 17'h1FFFF, 17'd65535,
                                                   17'd7};

  // applies one edit to the shadow state and returns the result it must produce
  function automatic reply_t sequence_edit(edit_req_t req);
    reply_t           rep;
    oteps_pkg::kind_e kind;
    int unsigned      pos;
    logic [VER_W-1:0] ver;
    int unsigned      lim;
    int unsigned      drop;
    hist_entry_t      prev;
    rep.status = oteps_pkg::ST_OK;
    kind = oteps_pkg::KIND_NOOP;
    pos = 0;
    // rejection order: bad kind, multi-char insert, expired base, base ahead
    if (req.kind == oteps_pkg::KIND_BAD) rep.status = oteps_pkg::ST_INVALID;
    else if (req.kind == oteps_pkg::KIND_INS && !req.single)
      rep.status = oteps_pkg::ST_NOT_ONE_CHAR;
    else if (req.base < start_ver) rep.status = oteps_pkg::ST_EXPIRED;
    else if (req.base > ver_now) rep.status = oteps_pkg::ST_AHEAD;
    if (rep.status == oteps_pkg::ST_OK) begin
      kind = req.kind;
      pos = (req.kind == oteps_pkg::KIND_NOOP) ? 0 : 32'(req.pos);
      // oldest entry first; only versions the client had not seen move the edit
      for (int unsigned i = 0; i < hist_fill; i++) begin
        ver = ver_now - VER_W'(hist_fill) + VER_W'(1) + VER_W'(i);
        prev = hist_mem[(hist_head + i) % HISTORY_DEPTH];
        if (ver > req.base && kind != oteps_pkg::KIND_NOOP &&
            prev.kind != oteps_pkg::KIND_NOOP) begin
          if (prev.kind == oteps_pkg::KIND_INS) begin
            if (32'(prev.pos) <= pos) pos++;
          end else if (prev.kind == oteps_pkg::KIND_DEL) begin
            if (32'(prev.pos) < pos) begin
              pos--;
            end else if (32'(prev.pos) == pos && kind == oteps_pkg::KIND_DEL) begin
              // both deleted the same character
              kind = oteps_pkg::KIND_NOOP;
              pos = 0;
            end
          end
        end
      end
      // fit the edit to the current length
      if (kind == oteps_pkg::KIND_INS) begin
        if (32'(len_now) >= MAX_CHARS) begin
          kind = oteps_pkg::KIND_NOOP;
          pos = 0;
        end else begin
          if (pos > 32'(len_now)) pos = 32'(len_now);
          len_now++;
        end
      end else if (kind == oteps_pkg::KIND_DEL) begin
        if (pos < 32'(len_now)) begin
          len_now--;
        end else begin
          kind = oteps_pkg::KIND_NOOP;
          pos = 0;
        end
      end
      ver_now++;
      // append, dropping the oldest entries beyond the limit
      lim = (limit_reg == '0) ? DEFAULT_LIMIT : 32'(limit_reg);
      if (lim > HISTORY_DEPTH) lim = HISTORY_DEPTH;
      if (hist_fill >= lim) begin
        drop = hist_fill - lim + 1;
        hist_head = (hist_head + drop) % HISTORY_DEPTH;
        hist_fill -= drop;
      end
      hist_mem[(hist_head + hist_fill) % HISTORY_DEPTH] = '{kind: kind, pos: pos[POS_W-1:0]};
      hist_fill++;
      start_ver = ver_now - VER_W'(hist_fill);
    end
    rep.kind   = kind;
    rep.pos    = pos[POS_W-1:0];
    rep.ver    = ver_now;
    rep.oldest = start_ver;
    rep.len    = len_now;
    return rep;
  endfunction

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // random edit drawn against the current shadow state: mostly well formed, some noise
  function automatic edit_req_t pick_edit();
    edit_req_t        e;
    int unsigned      roll;
    int unsigned      mix;
    logic [VER_W-1:0] span;
    roll = $urandom_range(0, 99);
    e.single = 1'b1;
    e.kind = oteps_pkg::KIND_NOOP;
    e.pos = POS_W'($urandom_range(0, (len_now < 17'd65534) ? 32'(len_now) + 1 : 65535));
    span = ver_now - start_ver;
    if (roll < 4) begin
      e.kind = oteps_pkg::KIND_BAD;
      e.single = 1'($urandom_range(0, 1));
      e.base = $urandom;
      e.pos = POS_W'($urandom);
    end else if (roll < 8) begin
      e.kind = oteps_pkg::KIND_INS;
      e.single = 1'b0;
      e.base = ver_now;
    end else if (roll < 12) begin
      // full-range base, nearly always ahead of the server
      e.kind = oteps_pkg::kind_e'($urandom_range(0, 2));
      e.base = $urandom;
      e.pos = POS_W'($urandom);
    end else if (roll < 15 && start_ver != 0) begin
      e.kind = oteps_pkg::kind_e'($urandom_range(0, 2));
      e.base = $urandom_range(0, start_ver - 1);
    end else begin
      mix = $urandom_range(0, 9);
      e.kind = (mix == 0) ? oteps_pkg::KIND_NOOP :
               (mix < 6) ? oteps_pkg::KIND_INS : oteps_pkg::KIND_DEL;
      if ($urandom_range(0, 3) == 0) e.base = start_ver;
      else e.base = ver_now - $urandom_range(0, (span < 6) ? span : 6);
      if ($urandom_range(0, 15) == 0) e.pos = POS_W'($urandom);
    end
    return e;
  endfunction

  // write only while the sequencer is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == oteps_pkg::REG_HISTORY_LIMIT) begin
      limit_reg = value[LIMIT_W-1:0];
    end else begin
      len_now = (32'(value) > MAX_CHARS) ? LEN_W'(MAX_CHARS) : LEN_W'(value);
    end
  endtask

  task automatic post_edit(input edit_req_t e);
    edits_waiting.push_back(e);
    edits_posted++;
  endtask

  // every posted edit has come back as a result
  task automatic drain();
    while (replies_seen != edits_posted) @(posedge clk_i);
  endtask

  task automatic send_edit(input logic [VER_W-1:0] base, input oteps_pkg::kind_e kind,
                           input logic [POS_W-1:0] pos, input logic single);
    edit_req_t e;
    e.base = base;
    e.kind = kind;
    e.pos = pos;
    e.single = single;
    post_edit(e);
    drain();
  endtask

  // edit driver: holds tvalid until the transfer, random gaps between edits
  edit_req_t   next_edit;
  int unsigned send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (edits_waiting.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
        // random gap with tvalid low, starting with this one
        send_gap = $urandom_range(0, 14);
        s_axis_tvalid <= 1'b0;
      end else begin
        next_edit = edits_waiting.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, next_edit.single, next_edit.pos, next_edit.base};
        s_axis_tuser  <= next_edit.kind;
      end
    end
  end

  // result receiver: stalls in random bursts with tready low
  int unsigned stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: checks each result transfer, predicts each edit transfer
  edit_req_t taken_edit;
  reply_t    due;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        replies_seen++;
        if (replies_due.size() == 0) begin
          $error("result transfer with no edit pending: tuser %h tdata %h",
                 m_axis_tuser, m_axis_tdata);
          failures++;
        end else begin
          due = replies_due.pop_front();
          compare_field("status", due.status, m_axis_tuser[2:0]);
          compare_field("applied_kind", due.kind, m_axis_tuser[4:3]);
          compare_field("applied_pos", due.pos, m_axis_tdata[15:0]);
          compare_field("cur_version", due.ver, m_axis_tdata[47:16]);
          compare_field("oldest_base", due.oldest, m_axis_tdata[79:48]);
          compare_field("doc_length", due.len, m_axis_tdata[96:80]);
          status_tally[due.status]++;
          if (due.status == oteps_pkg::ST_OK) kind_tally[due.kind]++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        taken_edit.base   = s_axis_tdata[31:0];
        taken_edit.pos    = s_axis_tdata[47:32];
        taken_edit.single = s_axis_tdata[48];
        taken_edit.kind   = oteps_pkg::kind_e'(s_axis_tuser);
        replies_due.push_back(sequence_edit(taken_edit));
        edits_taken++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, replies_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [VER_W-1:0] b;
    int unsigned      sent;
    int unsigned      burst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty document, default history limit
    send_edit(32'd0, oteps_pkg::KIND_NOOP, 16'h1234, 1'b0);   // noop reports position 0
    send_edit(ver_now, oteps_pkg::KIND_INS, 16'd0, 1'b1);
    send_edit(ver_now, oteps_pkg::KIND_INS, 16'hFFFF, 1'b1);  // clamped to the end
    send_edit(ver_now, oteps_pkg::KIND_INS, 16'd1, 1'b1);
    // rejections, each one behind the one that takes priority
    send_edit(ver_now, oteps_pkg::KIND_INS, 16'd2, 1'b0);
    send_edit(ver_now, oteps_pkg::KIND_BAD, 16'd0, 1'b1);
    send_edit(32'hFFFF_FFFF, oteps_pkg::KIND_BAD, 16'hFFFF, 1'b0);
    send_edit(32'hFFFF_FFFF, oteps_pkg::KIND_INS, 16'd0, 1'b0);
    send_edit(32'hFFFF_FFFF, oteps_pkg::KIND_DEL, 16'd0, 1'b1);
    send_edit(ver_now, oteps_pkg::KIND_DEL, 16'hFFFF, 1'b1);  // past the end turns into a noop
    // concurrent edits from one base version
    b = ver_now;
    send_edit(b, oteps_pkg::KIND_DEL, 16'd0, 1'b1);
    send_edit(b, oteps_pkg::KIND_DEL, 16'd0, 1'b1);           // same character already gone
    send_edit(b, oteps_pkg::KIND_INS, 16'd1, 1'b1);
    send_edit(b, oteps_pkg::KIND_INS, 16'd1, 1'b1);
    send_edit(b - 32'd3, oteps_pkg::KIND_DEL, 16'd2, 1'b1);
    send_edit(32'd0, oteps_pkg::KIND_DEL, 16'd1, 1'b1);       // walks the whole history
    // short history: the limit shrinks at the next append, older bases expire
    write_reg(oteps_pkg::REG_HISTORY_LIMIT, 17'd2);
    send_edit(ver_now, oteps_pkg::KIND_INS, 16'd0, 1'b1);
    send_edit(start_ver - 32'd1, oteps_pkg::KIND_DEL, 16'd0, 1'b1);
    send_edit(start_ver, oteps_pkg::KIND_DEL, 16'd0, 1'b1);
    // oversized initial length saturates, a full document refuses inserts
    write_reg(oteps_pkg::REG_INITIAL_LENGTH, 17'h1FFFF);
    send_edit(ver_now, oteps_pkg::KIND_INS, 16'd100, 1'b1);
    send_edit(ver_now, oteps_pkg::KIND_DEL, 16'hFFFF, 1'b1);
    send_edit(ver_now, oteps_pkg::KIND_INS, 16'hFFFF, 1'b1);
    send_edit(ver_now - 32'd2, oteps_pkg::KIND_DEL, 16'hFFFF, 1'b1);
    send_edit(ver_now, oteps_pkg::KIND_INS, 16'd0, 1'b1);

    // random phases, each under its own limit and starting length
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == PHASES - 1) calm_tail = 1'b1;
      write_reg(oteps_pkg::REG_HISTORY_LIMIT, phase_limit[ph]);
      write_reg(oteps_pkg::REG_INITIAL_LENGTH, phase_length[ph]);
      sent = 0;
      while (sent < EDITS_PER_PHASE) begin
        // short bursts keep tvalid up across back-to-back edits
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
        repeat (burst) post_edit(pick_edit());
        sent += burst;
        drain();
      end
    end

    // nothing may follow the last result
    drain();
    repeat (HISTORY_DEPTH + 16) @(posedge clk_i);
    if (replies_due.size() != 0) begin
      $error("%0d results never arrived", replies_due.size());
      failures++;
    end

    $display("%0d edits: %0d ok, %0d bad kind, %0d multi-char, %0d expired, %0d ahead",
             edits_taken, status_tally[oteps_pkg::ST_OK], status_tally[oteps_pkg::ST_INVALID],
             status_tally[oteps_pkg::ST_NOT_ONE_CHAR], status_tally[oteps_pkg::ST_EXPIRED],
             status_tally[oteps_pkg::ST_AHEAD]);
    $display("applied %0d inserts, %0d deletes, %0d noops over %0d limit settings",
             kind_tally[oteps_pkg::KIND_INS], kind_tally[oteps_pkg::KIND_DEL],
             kind_tally[oteps_pkg::KIND_NOOP], PHASES + 2);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/oteps_pkg.sv
rtl/core/oteps_hist_mem.sv
rtl/core/oteps_walker.sv
rtl/core/ot_edit_position_sequencer.sv
test/testbench.sv
